// File: rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants of the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

	// default capacity in items
	localparam int DEPTH_DEF = 16;

	// widths of the item fields
	localparam int ITEM_W   = 32;
	localparam int ACTION_W = 3;
	localparam int STATUS_W = 2;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_PUSH_REAR  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_POP_REAR   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_PEEK_FRONT = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_PEEK_REAR  = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// value returned by a peek on an empty queue
	localparam logic [ITEM_W-1:0] EMPTY_PEEK_VALUE = 32'h8000_0001;

	// controller to datapath commands
	typedef struct packed {
		logic take;     // input item accepted this cycle
		logic rd_done;  // store read data valid, load it as result
	} bdq_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic needs_read;  // offered item must fetch from the store
		logic out_free;    // result register free at the next edge
	} bdq_stat_t;

endpackage

// File: rtl/bounded_deque_unit.sv
// ----------------------------------------------------------------------------
// bounded_deque_unit
// Double-ended queue of DEPTH signed 32-bit items in a circular store.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_*) takes one action per item: s_tuser holds the
//   action code (push front, push rear, pop front, pop rear, peek front,
//   peek rear) and s_tdata the value to push. Each item yields exactly one
//   result on the output channel (m_*): m_tdata holds the popped or peeked
//   value and the occupancy after the action, m_tuser the status (ok, full,
//   empty).
//   Pushes, refused actions and actions on an empty queue load the result
//   register at the edge that accepts them; pops and peeks of a held item pass
//   through the registered read port of the item store first. One item per
//   cycle for pushes while the result register frees up in time; a pop or
//   peek that reads the store holds off the next item until its read is done.
//   Reset clears the head index, the count and the result valid flag; the
//   store itself is not cleared and needs no clearing pass.
//   While the receiver stalls, the result waits in the output register
//   and a further item is taken only when that register frees up.
// ----------------------------------------------------------------------------
module bounded_deque_unit #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1),
	parameter int OUT_W = ((bdq_pkg::ITEM_W + CNT_W + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bdq_pkg::ITEM_W-1:0]       s_tdata,   // [31:0] item_in
	input  logic [bdq_pkg::ACTION_W-1:0]     s_tuser,   // [2:0] action
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [OUT_W-1:0]                 m_tdata,   // item_out, occupancy, zero fill
	output logic [bdq_pkg::STATUS_W-1:0]     m_tuser    // [1:0] status
);

	bdq_pkg::bdq_cmd_t  cmd;
	bdq_pkg::bdq_stat_t stat;

	logic [bdq_pkg::ITEM_W-1:0] item_out;
	logic [CNT_W-1:0]           occupancy;

	// controller
	bdq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// datapath
	bdq_dpath #(
		.DEPTH(DEPTH),
		.CNT_W(CNT_W)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.action   (s_tuser),
		.item_in  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.item_out (item_out),
		.status   (m_tuser),
		.occupancy(occupancy)
	);

	// output packing, item value in the low bits
	assign m_tdata = OUT_W'({occupancy, item_out});

endmodule

// File: rtl/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one access per cycle, read data registered
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// File: rtl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Controller: accepts items and sequences the store read of pops and peeks.
// ----------------------------------------------------------------------------
module bdq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  bdq_pkg::bdq_stat_t stat,
	output bdq_pkg::bdq_cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic state_q;
	logic state_d;

	// ready only when idle and the result register can take a new result
	assign s_tready    = (state_q == ST_IDLE) && stat.out_free;
	assign cmd.take    = s_tvalid && s_tready;
	assign cmd.rd_done = (state_q == ST_READ);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.take && stat.needs_read) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/bdq_dpath.sv
// ----------------------------------------------------------------------------
// bdq_dpath
// Datapath: head index, occupancy count, item store and result register.
// ----------------------------------------------------------------------------
module bdq_dpath #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bdq_pkg::bdq_cmd_t                cmd,
	output bdq_pkg::bdq_stat_t               stat,
	input  logic [bdq_pkg::ACTION_W-1:0]     action,
	input  logic [bdq_pkg::ITEM_W-1:0]       item_in,
	input  logic                             m_tready,
	output logic                             m_tvalid,
	output logic [bdq_pkg::ITEM_W-1:0]       item_out,
	output logic [bdq_pkg::STATUS_W-1:0]     status,
	output logic [CNT_W-1:0]                 occupancy
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [IDX_W:0]   DEPTH_SUM = (IDX_W + 1)'(DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] head_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             out_valid_q;

	logic             empty;
	logic             full;
	logic [IDX_W-1:0] head_prev;
	logic [IDX_W-1:0] head_next;
	logic [IDX_W-1:0] last_off;
	logic [IDX_W:0]   rear_sum;
	logic [IDX_W:0]   last_sum;
	logic [IDX_W-1:0] rear_slot;
	logic [IDX_W-1:0] last_slot;

	logic                         ram_en;
	logic                         ram_we;
	logic [IDX_W-1:0]             ram_addr;
	logic [bdq_pkg::ITEM_W-1:0]   ram_rdata;

	logic [bdq_pkg::ITEM_W-1:0]   res_item;
	logic [bdq_pkg::STATUS_W-1:0] res_status;
	logic                         needs_read;

	assign empty = (count_q == '0);
	assign full  = (count_q >= FULL_CNT);

	// neighbor slots of the head, wrapping at the capacity
	assign head_prev = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;

	// slot after the last item and slot of the last item
	assign last_off  = IDX_W'(count_q - 1'b1);
	assign rear_sum  = {1'b0, head_q} + {1'b0, IDX_W'(count_q)};
	assign last_sum  = {1'b0, head_q} + {1'b0, last_off};
	assign rear_slot = (rear_sum >= DEPTH_SUM) ? IDX_W'(rear_sum - DEPTH_SUM)
		: rear_sum[IDX_W-1:0];
	assign last_slot = (last_sum >= DEPTH_SUM) ? IDX_W'(last_sum - DEPTH_SUM)
		: last_sum[IDX_W-1:0];

	// action decode
	always_comb begin
		head_d     = head_q;
		count_d    = count_q;
		ram_en     = 1'b0;
		ram_we     = 1'b0;
		ram_addr   = head_q;
		res_item   = '0;
		res_status = bdq_pkg::ST_OK;
		needs_read = 1'b0;
		case (action)
			bdq_pkg::ACT_PUSH_FRONT: begin
				if (full) begin
					res_status = bdq_pkg::ST_FULL;
				end else begin
					head_d   = head_prev;
					count_d  = count_q + 1'b1;
					ram_en   = 1'b1;
					ram_we   = 1'b1;
					ram_addr = head_prev;
				end
			end
			bdq_pkg::ACT_PUSH_REAR: begin
				if (full) begin
					res_status = bdq_pkg::ST_FULL;
				end else begin
					count_d  = count_q + 1'b1;
					ram_en   = 1'b1;
					ram_we   = 1'b1;
					ram_addr = rear_slot;
				end
			end
			bdq_pkg::ACT_POP_FRONT: begin
				if (empty) begin
					res_status = bdq_pkg::ST_EMPTY;
				end else begin
					head_d     = head_next;
					count_d    = count_q - 1'b1;
					ram_en     = 1'b1;
					needs_read = 1'b1;
				end
			end
			bdq_pkg::ACT_POP_REAR: begin
				if (empty) begin
					res_status = bdq_pkg::ST_EMPTY;
				end else begin
					count_d    = count_q - 1'b1;
					ram_en     = 1'b1;
					ram_addr   = last_slot;
					needs_read = 1'b1;
				end
			end
			bdq_pkg::ACT_PEEK_FRONT: begin
				if (empty) begin
					res_item   = bdq_pkg::EMPTY_PEEK_VALUE;
					res_status = bdq_pkg::ST_EMPTY;
				end else begin
					ram_en     = 1'b1;
					needs_read = 1'b1;
				end
			end
			bdq_pkg::ACT_PEEK_REAR: begin
				if (empty) begin
					res_item   = bdq_pkg::EMPTY_PEEK_VALUE;
					res_status = bdq_pkg::ST_EMPTY;
				end else begin
					ram_en     = 1'b1;
					ram_addr   = last_slot;
					needs_read = 1'b1;
				end
			end
			default: begin
				res_status = bdq_pkg::ST_OK;
			end
		endcase
	end

	assign stat.needs_read = needs_read;
	assign stat.out_free   = !out_valid_q || m_tready;

	// item store
	bdq_ram #(
		.WIDTH(bdq_pkg::ITEM_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.en   (ram_en && cmd.take),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(item_in),
		.rdata(ram_rdata)
	);

	// head index and occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.take) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.take && !needs_read) || cmd.rd_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.take && !needs_read) begin
			item_out  <= res_item;
			status    <= res_status;
			occupancy <= count_d;
		end else if (cmd.rd_done) begin
			item_out  <= ram_rdata;
			status    <= bdq_pkg::ST_OK;
			occupancy <= count_q;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bounded_deque_unit. A behavioral deque model
// predicts item_out, status and occupancy for every accepted action. Each
// result leaving the block is compared against the oldest prediction.
// Directed runs cover the empty and full corners and the extreme values.
// Random runs swing between fill-heavy, drain-heavy and mixed traffic.
// Both handshake sides stall at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int QDEPTH  = bdq_pkg::DEPTH_DEF;
	localparam int ITEM_W  = bdq_pkg::ITEM_W;
	localparam int ACT_W   = bdq_pkg::ACTION_W;
	localparam int STAT_W  = bdq_pkg::STATUS_W;
	localparam int CNT_W   = $clog2(QDEPTH + 1);
	localparam int OUT_W   = ((ITEM_W + CNT_W + 7) / 8) * 8;
	localparam int MAX_GAP = 17;

	// bias of the random action mix
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} action_mix_t;

	typedef struct packed {
		logic [ITEM_W-1:0] value;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  occupancy;
	} deque_result_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [ITEM_W-1:0] s_tdata;   // [31:0] item_in
	logic [ACT_W-1:0]  s_tuser;   // [2:0] action
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;   // [31:0] item_out, [36:32] occupancy, zero fill
	logic [STAT_W-1:0] m_tuser;   // [1:0] status

	// predicted results still waiting for the block
	deque_result_t pending_results[$];

	// shadow copy of the deque contents
	logic [ITEM_W-1:0] shadow_store [QDEPTH];
	int unsigned       shadow_head;
	int unsigned       shadow_count;

	int unsigned mismatches;
	bit          send_burst;
	bit          recv_burst;

	bounded_deque_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// apply one action to the shadow deque and return its result
	function automatic deque_result_t apply_action(input logic [ACT_W-1:0] action,
			input logic [ITEM_W-1:0] value);
		deque_result_t r;
		int unsigned   rear;
		r.value  = '0;
		r.status = bdq_pkg::ST_OK;
		rear = (shadow_head + shadow_count + QDEPTH - 1) % QDEPTH;
		case (action)
			bdq_pkg::ACT_PUSH_FRONT, bdq_pkg::ACT_PUSH_REAR: begin
				if (shadow_count >= QDEPTH) begin
					r.status = bdq_pkg::ST_FULL;
				end else if (action == bdq_pkg::ACT_PUSH_FRONT) begin
					shadow_head = (shadow_head + QDEPTH - 1) % QDEPTH;
					shadow_store[shadow_head] = value;
					shadow_count++;
				end else begin
					shadow_store[(shadow_head + shadow_count) % QDEPTH] = value;
					shadow_count++;
				end
			end
			bdq_pkg::ACT_POP_FRONT, bdq_pkg::ACT_POP_REAR: begin
				if (shadow_count == 0) begin
					r.status = bdq_pkg::ST_EMPTY;
				end else if (action == bdq_pkg::ACT_POP_FRONT) begin
					r.value = shadow_store[shadow_head];
					shadow_head = (shadow_head + 1) % QDEPTH;
					shadow_count--;
				end else begin
					r.value = shadow_store[rear];
					shadow_count--;
				end
			end
			bdq_pkg::ACT_PEEK_FRONT, bdq_pkg::ACT_PEEK_REAR: begin
				if (shadow_count == 0) begin
					r.value  = bdq_pkg::EMPTY_PEEK_VALUE;
					r.status = bdq_pkg::ST_EMPTY;
				end else begin
					r.value = (action == bdq_pkg::ACT_PEEK_FRONT)
						? shadow_store[shadow_head] : shadow_store[rear];
				end
			end
			default: ;
		endcase
		r.occupancy = shadow_count[CNT_W-1:0];
		return r;
	endfunction

	function automatic logic [ITEM_W-1:0] random_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return bdq_pkg::EMPTY_PEEK_VALUE;
			3: return 32'hffff_ffff;
			4: return 32'h0000_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [ACT_W-1:0] pick_action(input action_mix_t mix);
		int roll;
		roll = $urandom_range(0, 99);
		if (mix == MIX_FILL && roll < 70)
			return $urandom_range(0, 1) ? bdq_pkg::ACT_PUSH_REAR : bdq_pkg::ACT_PUSH_FRONT;
		if (mix == MIX_DRAIN && roll < 70)
			return $urandom_range(0, 1) ? bdq_pkg::ACT_POP_REAR : bdq_pkg::ACT_POP_FRONT;
		case ($urandom_range(0, 5))
			0: return bdq_pkg::ACT_PUSH_FRONT;
			1: return bdq_pkg::ACT_PUSH_REAR;
			2: return bdq_pkg::ACT_POP_FRONT;
			3: return bdq_pkg::ACT_POP_REAR;
			4: return bdq_pkg::ACT_PEEK_FRONT;
			default: return bdq_pkg::ACT_PEEK_REAR;
		endcase
	endfunction

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, what);
	endtask

	// offer one item after a random gap and predict it once taken
	task automatic send_item(input logic [ACT_W-1:0] action, input logic [ITEM_W-1:0] value);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= action;
		s_tdata  <= value;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		pending_results.push_back(apply_action(action, value));
	endtask

	task automatic test_empty_queue();
		send_item(bdq_pkg::ACT_POP_FRONT, 32'h1234_5678);
		send_item(bdq_pkg::ACT_POP_REAR, 32'hffff_ffff);
		send_item(bdq_pkg::ACT_PEEK_FRONT, 32'h0000_0000);
		send_item(bdq_pkg::ACT_PEEK_REAR, 32'h8000_0000);
	endtask

	// fill with extreme values, including the empty-peek value as an item
	task automatic test_fill_to_capacity();
		send_item(bdq_pkg::ACT_PUSH_REAR, 32'h7fff_ffff);
		send_item(bdq_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
		send_item(bdq_pkg::ACT_PUSH_REAR, bdq_pkg::EMPTY_PEEK_VALUE);
		send_item(bdq_pkg::ACT_PUSH_FRONT, 32'hffff_ffff);
		send_item(bdq_pkg::ACT_PUSH_REAR, 32'h0000_0000);
		for (int i = 5; i < QDEPTH; i++)
			send_item((i % 2) ? bdq_pkg::ACT_PUSH_FRONT : bdq_pkg::ACT_PUSH_REAR,
				$urandom());
		send_item(bdq_pkg::ACT_PUSH_FRONT, 32'h5555_5555);
		send_item(bdq_pkg::ACT_PUSH_REAR, 32'haaaa_aaaa);
		send_item(bdq_pkg::ACT_PEEK_FRONT, 32'h0);
		send_item(bdq_pkg::ACT_PEEK_REAR, 32'h0);
		send_item(bdq_pkg::ACT_POP_FRONT, 32'h0);
		send_item(bdq_pkg::ACT_POP_REAR, 32'h0);
	endtask

	task automatic test_random_traffic(input int count, input int phase);
		action_mix_t mix;
		mix = MIX_EVEN;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				mix = action_mix_t'((i / 50 + phase) % 3);
				send_burst = ((i / 50) % 4 == 1);
				recv_burst = ((i / 50) % 5 == 2);
			end
			send_item(pick_action(mix), random_value());
		end
		send_burst = 1'b0;
		recv_burst = 1'b0;
	endtask

	// hold the sender until every predicted result has come back
	task automatic test_pause_until_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// receiver: random stall before each result
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!m_tvalid);
			@(posedge clk);
		end
	end

	// compare each result taken at the coming edge with the oldest prediction
	always @(negedge clk) begin
		deque_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("unexpected result data=%h status=%0d",
					m_tdata, m_tuser));
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[ITEM_W-1:0] !== want.value || m_tuser !== want.status
						|| m_tdata[ITEM_W +: CNT_W] !== want.occupancy
						|| m_tdata[OUT_W-1:ITEM_W+CNT_W] !== '0)
					note_mismatch($sformatf(
						"expected %h st %0d occ %0d, got %h st %0d occ %0d fill %b",
						want.value, want.status, want.occupancy, m_tdata[ITEM_W-1:0],
						m_tuser, m_tdata[ITEM_W +: CNT_W], m_tdata[OUT_W-1:ITEM_W+CNT_W]));
			end
		end
	end

	// run limit
	initial begin
		#400000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = bdq_pkg::ACT_PEEK_FRONT;
		shadow_head  = 0;
		shadow_count = 0;
		mismatches   = 0;
		send_burst   = 1'b0;
		recv_burst   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_queue();
		test_fill_to_capacity();
		test_random_traffic(300, 0);
		test_pause_until_drained();
		test_random_traffic(250, 1);

		// let the last results drain, then idle on a while for strays
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
